// ===== rtl/dfmp_pkg.sv =====
`default_nettype none

package dfmp_pkg;

  localparam int FRAME_LEN = 13;
  localparam int HEX_LEN   = 26;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] nib_t;
  typedef logic [4:0] fill_t;
  typedef logic [3:0] count_t;

  localparam byte_t START_A    = 8'h01;
  localparam byte_t START_B    = 8'h02;
  localparam byte_t CMD_BYTE   = 8'hFD;
  localparam byte_t CHECK_BYTE = 8'h6B;

  localparam fill_t  HEX_FULL  = fill_t'(HEX_LEN);
  localparam count_t FRAME_CNT = count_t'(FRAME_LEN);
  localparam count_t BIN_LAST  = count_t'(FRAME_LEN - 1);

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic ok;
    nib_t val;
  } hex_t;

  function automatic hex_t hex_decode(input byte_t c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = nib_t'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = nib_t'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = nib_t'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dfmp_hex_cell.sv =====
`default_nettype none

module dfmp_hex_cell (
  input  wire            clk,
  input  wire            shift,
  input  dfmp_pkg::nib_t nib_in,
  output dfmp_pkg::byte_t q,
  output dfmp_pkg::byte_t q_next
);
  import dfmp_pkg::*;

  assign q_next = {q[3:0], nib_in};

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfmp_byte_cell.sv =====
`default_nettype none

module dfmp_byte_cell (
  input  wire                 clk,
  input  dfmp_pkg::cell_ctrl_t ctrl,
  input  dfmp_pkg::byte_t     load_data,
  input  dfmp_pkg::byte_t     shift_in,
  output dfmp_pkg::byte_t     q
);
  import dfmp_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= load_data;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_format_motor_frame_parser_core.sv =====
`default_nettype none
// Channel | Dir | Handshake          | Payload
// input   | in  | in_valid/in_stall  | rx_byte
// output  | out | out_valid/out_stall | out_port, out_byte, frame_last
//
// One received byte is taken per cycle unless in_stall; a completed frame
// leaves as 13 transactions, one per cycle unless out_stall, from a 13-cell
// output chain. The input stalls only when a byte would complete a frame
// while the output chain still holds the previous one.
// rst is synchronous and clears the fill counters and the output count.

module dual_format_motor_frame_parser_core (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  dfmp_pkg::byte_t rx_byte,
  output logic            out_valid,
  input  wire             out_stall,
  output logic            out_port,
  output dfmp_pkg::byte_t out_byte,
  output logic            frame_last
);
  import dfmp_pkg::*;

  byte_t hex_q    [FRAME_LEN];
  byte_t hex_post [FRAME_LEN];
  byte_t bin_q    [FRAME_LEN];
  byte_t bin_post [FRAME_LEN];
  byte_t out_q    [FRAME_LEN];
  byte_t frame_src[FRAME_LEN];

  fill_t  hex_fill, hex_fill_next, fill_step;
  count_t bin_count, bin_count_next;
  count_t out_cnt, out_cnt_next;

  hex_t hd;
  logic acc, is_start, hex_hit, hex_emit, bin_append, bin_done, bin_emit;
  logic would_emit, advance, load;
  cell_ctrl_t bin_ctrl, out_ctrl;

  assign hd       = hex_decode(rx_byte);
  assign is_start = (rx_byte == START_A) || (rx_byte == START_B);
  assign acc      = in_valid && !in_stall;

  genvar i;
  generate
    for (i = 0; i < FRAME_LEN; i++) begin : g_cells
      nib_t  nib_src;
      byte_t bin_src;
      byte_t out_src;
      if (i < FRAME_LEN - 1) begin : g_mid
        assign nib_src = hex_q[i+1][7:4];
        assign bin_src = bin_q[i+1];
        assign out_src = out_q[i+1];
      end else begin : g_end
        assign nib_src = hd.val;
        assign bin_src = rx_byte;
        assign out_src = '0;
      end
      assign bin_post[i]  = bin_src;
      assign frame_src[i] = hex_emit ? hex_post[i] : bin_post[i];

      dfmp_hex_cell u_hex (
        .clk    (clk),
        .shift  (acc && hd.ok),
        .nib_in (nib_src),
        .q      (hex_q[i]),
        .q_next (hex_post[i])
      );

      dfmp_byte_cell u_bin (
        .clk       (clk),
        .ctrl      (bin_ctrl),
        .load_data (byte_t'(0)),
        .shift_in  (bin_src),
        .q         (bin_q[i])
      );

      dfmp_byte_cell u_out (
        .clk       (clk),
        .ctrl      (out_ctrl),
        .load_data (frame_src[i]),
        .shift_in  (out_src),
        .q         (out_q[i])
      );
    end
  endgenerate

  always_comb begin
    fill_step  = (hex_fill == HEX_FULL) ? HEX_FULL : fill_t'(hex_fill + 1'b1);
    hex_hit    = hd.ok && (fill_step == HEX_FULL) &&
                 ((hex_post[0] == START_A) || (hex_post[0] == START_B)) &&
                 (hex_post[1] == CMD_BYTE);
    hex_emit   = hex_hit && (hex_post[FRAME_LEN-1] == CHECK_BYTE);
    bin_append = !hd.ok && !is_start && (bin_count != '0);
    bin_done   = bin_append && (bin_count == BIN_LAST);
    bin_emit   = bin_done && (bin_post[1] == CMD_BYTE) &&
                 (bin_post[FRAME_LEN-1] == CHECK_BYTE);
    would_emit = hex_emit || bin_emit;
    in_stall   = would_emit && out_valid;
    load       = acc && would_emit;
    advance    = out_valid && !out_stall;
    bin_ctrl   = '{load: 1'b0, shift: acc && (is_start || bin_append)};
    out_ctrl   = '{load: load, shift: advance};
  end

  always_comb begin
    hex_fill_next  = hex_fill;
    bin_count_next = bin_count;
    if (acc) begin
      if (hd.ok) begin
        hex_fill_next  = hex_hit ? '0 : fill_step;
        bin_count_next = '0;
      end else if (is_start) begin
        hex_fill_next  = '0;
        bin_count_next = count_t'(1);
      end else if (bin_append) begin
        bin_count_next = bin_done ? '0 : count_t'(bin_count + 1'b1);
      end
    end
    out_cnt_next = out_cnt;
    if (load) begin
      out_cnt_next = FRAME_CNT;
    end else if (advance) begin
      out_cnt_next = count_t'(out_cnt - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_fill  <= '0;
      bin_count <= '0;
      out_cnt   <= '0;
    end else begin
      hex_fill  <= hex_fill_next;
      bin_count <= bin_count_next;
      out_cnt   <= out_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_port <= (frame_src[0] != START_A);
    end
  end

  assign out_valid  = (out_cnt != '0);
  assign out_byte   = out_q[0];
  assign frame_last = (out_cnt == count_t'(1));

endmodule

`default_nettype wire

// ===== rtl/dfmp_checker.sv =====
`default_nettype none

module dfmp_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire [7:0] rx_byte,
  input wire       out_valid,
  input wire       out_stall,
  input wire       out_port,
  input wire [7:0] out_byte,
  input wire       frame_last
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(rx_byte))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_port)
      && $stable(frame_last))
    else $error("output changed while stalled");

  a_frame_contig: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !frame_last |=> out_valid && $stable(out_port))
    else $error("frame broken before last byte");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(frame_last && !out_stall))
    else $error("output ended without last byte");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with idle output");

endmodule

bind dual_format_motor_frame_parser_core dfmp_checker u_dfmp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .rx_byte    (rx_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_port   (out_port),
  .out_byte   (out_byte),
  .frame_last (frame_last)
);

`default_nettype wire

// ===== sim/tb_dual_format_motor_frame_parser_core.sv =====
`timescale 1ns / 1ps

module tb_dual_format_motor_frame_parser_core;
  import dfmp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {SEQ_HEX, SEQ_BIN, SEQ_NOISE} seq_kind_e;

  typedef struct {
    logic  port;
    byte_t data;
    logic  last;
  } fwd_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  byte_t rx_byte = '0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  logic  out_port;
  byte_t out_byte;
  logic  frame_last;

  dual_format_motor_frame_parser_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_port(out_port),
    .out_byte(out_byte),
    .frame_last(frame_last)
  );

  // parser state mirror
  nib_t  win [HEX_LEN];
  int    win_fill = 0;
  byte_t bin_buf [FRAME_LEN];
  int    bin_cnt = 0;
  byte_t frm [FRAME_LEN];
  byte_t pkt [FRAME_LEN];
  fwd_t  fwd_bytes_q [$];
  fwd_t  head;

  int bytes_sent = 0;
  int frames_fwd = 0;
  int results_seen = 0;
  int errors = 0;
  int quiet = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit to_nibble(input byte_t c, output nib_t n);
    n = '0;
    to_nibble = 1'b1;
    if (c inside {[8'h30:8'h39]}) begin
      n = c[3:0];
    end else if (c inside {[8'h41:8'h46]} || c inside {[8'h61:8'h66]}) begin
      n = c[3:0] + 4'd9;
    end else begin
      to_nibble = 1'b0;
    end
  endfunction

  function automatic byte_t hex_char(input nib_t n, input bit upper);
    if (n < 4'd10) begin
      return 8'h30 + byte_t'(n);
    end
    return (upper ? 8'h41 : 8'h61) + byte_t'(n) - 8'd10;
  endfunction

  function automatic byte_t plain_byte();
    byte_t b;
    nib_t n;
    do begin
      b = byte_t'($urandom);
    end while (to_nibble(b, n) || b == START_A || b == START_B);
    return b;
  endfunction

  function automatic void queue_frame();
    fwd_t f;
    for (int k = 0; k < FRAME_LEN; k++) begin
      f.port = (frm[0] != START_A);
      f.data = frm[k];
      f.last = (k == FRAME_LEN - 1);
      fwd_bytes_q.push_back(f);
    end
    frames_fwd++;
  endfunction

  function automatic void track_rx_byte(input byte_t c);
    nib_t n;
    if (to_nibble(c, n)) begin
      bin_cnt = 0;
      if (win_fill == HEX_LEN) begin
        for (int i = 0; i < HEX_LEN - 1; i++) win[i] = win[i + 1];
        win_fill = HEX_LEN - 1;
      end
      win[win_fill] = n;
      win_fill++;
      if (win_fill == HEX_LEN && win[0] == 4'h0 && (win[1] == 4'h1 || win[1] == 4'h2) &&
          win[2] == 4'hF && win[3] == 4'hD) begin
        for (int i = 0; i < FRAME_LEN; i++) frm[i] = {win[2 * i], win[2 * i + 1]};
        win_fill = 0;
        if (frm[FRAME_LEN - 1] == CHECK_BYTE) queue_frame();
      end
    end else if (c == START_A || c == START_B) begin
      win_fill = 0;
      bin_buf[0] = c;
      bin_cnt = 1;
    end else if (bin_cnt > 0) begin
      bin_buf[bin_cnt] = c;
      bin_cnt++;
      if (bin_cnt == FRAME_LEN) begin
        bin_cnt = 0;
        if (bin_buf[1] == CMD_BYTE && bin_buf[FRAME_LEN - 1] == CHECK_BYTE) begin
          frm = bin_buf;
          queue_frame();
        end
      end
    end
  endfunction

  task automatic send_byte(input byte_t b);
    while (tx_gaps && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic fill_pkt(input bit good, input bit bin);
    pkt[0] = $urandom_range(0, 1) ? START_A : START_B;
    pkt[1] = CMD_BYTE;
    for (int i = 2; i < FRAME_LEN - 1; i++) pkt[i] = bin ? plain_byte() : byte_t'($urandom);
    pkt[FRAME_LEN - 1] = CHECK_BYTE;
    if (!good) begin
      if ($urandom_range(0, 1)) begin
        pkt[1] = bin ? plain_byte() : byte_t'($urandom);
        if (pkt[1] == CMD_BYTE) pkt[1] = 8'hFE;
      end else begin
        pkt[FRAME_LEN - 1] = pkt[FRAME_LEN - 1] ^ byte_t'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic send_pkt_hex();
    for (int i = 0; i < FRAME_LEN; i++) begin
      send_byte(hex_char(pkt[i][7:4], bit'($urandom_range(0, 1))));
      send_byte(hex_char(pkt[i][3:0], bit'($urandom_range(0, 1))));
    end
  endtask

  task automatic send_pkt_bin();
    for (int i = 0; i < FRAME_LEN; i++) send_byte(pkt[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fwd_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  task automatic test_binary_frames();
    fill_pkt(1'b1, 1'b1);
    pkt[0] = START_B;
    pkt[2] = 8'h00;
    pkt[3] = 8'hFF;
    send_pkt_bin();
    send_byte(START_A);
    send_byte(CMD_BYTE);
    send_byte(8'h61);
  endtask

  task automatic test_hex_frames();
    fill_pkt(1'b1, 1'b0);
    pkt[0] = START_A;
    send_pkt_hex();
  endtask

  task automatic test_random_traffic(input int n_bytes, input bit tx_idle, input bit rx_idle);
    seq_kind_e kind;
    int stop_at;
    int pick;
    stop_at = bytes_sent + n_bytes;
    tx_gaps = tx_idle;
    rx_gaps = rx_idle;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? SEQ_HEX : (pick < 75) ? SEQ_BIN : SEQ_NOISE;
      case (kind)
        SEQ_HEX: begin
          repeat ($urandom_range(0, 3))
            send_byte(hex_char(nib_t'($urandom), bit'($urandom_range(0, 1))));
          fill_pkt($urandom_range(0, 99) < 85, 1'b0);
          send_pkt_hex();
        end
        SEQ_BIN: begin
          fill_pkt($urandom_range(0, 99) < 85, 1'b1);
          if ($urandom_range(0, 99) < 10) pkt[$urandom_range(2, FRAME_LEN - 1)] = START_A;
          send_pkt_bin();
        end
        default: begin
          repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_req = 250;
    repeat (4) begin
      fill_pkt(1'b1, 1'b1);
      send_pkt_bin();
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= rx_gaps && ($urandom_range(0, 99) < 28);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (fwd_bytes_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output: port=%0d byte=%02h last=%0d", out_port, out_byte,
                   frame_last);
        end
      end else begin
        head = fwd_bytes_q.pop_front();
        if (out_port !== head.port || out_byte !== head.data || frame_last !== head.last) begin
          errors++;
          if (errors <= 10) begin
            $display(
              "mismatch: expected port=%0d byte=%02h last=%0d, got port=%0d byte=%02h last=%0d",
              head.port, head.data, head.last, out_port, out_byte, frame_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ignored_bytes();
    test_binary_frames();
    test_hex_frames();
    test_random_traffic(80, 1'b1, 1'b1);
    test_backpressure();
    test_random_traffic(40, 1'b0, 1'b0);
    wait_drain();
    test_random_traffic(80, 1'b1, 1'b1);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d bytes over hex, binary and noise traffic; %0d frames forwarded",
             bytes_sent, frames_fwd);
    $display("checked %0d output transactions, %0d mismatches", results_seen, errors);
    if (errors == 0 && fwd_bytes_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dfmp_pkg.sv
rtl/dfmp_hex_cell.sv
rtl/dfmp_byte_cell.sv
rtl/dual_format_motor_frame_parser_core.sv
rtl/dfmp_checker.sv
sim/tb_dual_format_motor_frame_parser_core.sv
